// ----- rtl/afp_pkg.sv -----
package afp_pkg;

    localparam int unsigned MaxFrameDefault = 1024;
    localparam int unsigned CfgIdxW         = 3;
    localparam int unsigned CfgDataW        = 11;
    localparam int unsigned LenW            = 11;
    localparam int unsigned ExpW            = 17;
    localparam int unsigned BoundW          = 18;

    // configuration register indexes
    localparam logic [CfgIdxW-1:0] CFG_ESCAPED_MODE    = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_FRAME_DELIMITER = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_ESCAPE_MARKER   = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_ESCAPE_XOR      = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_CHECKSUM_SEED   = 3'd4;
    localparam logic [CfgIdxW-1:0] CFG_MAX_FRAME_BYTES = 3'd5;

    localparam logic [7:0]      RstFrameDelimiter = 8'd126;
    localparam logic [7:0]      RstEscapeMarker   = 8'd125;
    localparam logic [7:0]      RstEscapeXor      = 8'd32;
    localparam logic [7:0]      RstChecksumSeed   = 8'd255;
    localparam logic [LenW-1:0] RstMaxFrameBytes  = 11'd1024;

    typedef struct packed {
        logic            escaped_mode;
        logic [7:0]      frame_delimiter;
        logic [7:0]      escape_marker;
        logic [7:0]      escape_xor;
        logic [7:0]      checksum_seed;
        logic [LenW-1:0] max_frame_bytes;
    } t_cfg;

    typedef struct packed {
        logic [7:0]      out_byte;
        logic            byte_valid;
        logic            frame_done;
        logic [LenW-1:0] frame_raw_length;
        logic [LenW-1:0] frame_data_length;
        logic            sync_lost;
    } t_result;

    // counter width: holds the largest possible limit plus one
    function automatic int unsigned afp_cnt_w(input int unsigned max_frame);
        int unsigned cap;
        cap = (max_frame < 2047) ? max_frame : 2047;
        return $clog2(cap + 2);
    endfunction

endpackage

// ----- rtl/afp_step.sv -----
module afp_step #(
    parameter int unsigned MAX_FRAME = afp_pkg::MaxFrameDefault
) (
    input  afp_pkg::t_cfg                                   i_cfg,
    input  logic [7:0]                                      i_byte,
    input  logic [afp_pkg::afp_cnt_w(MAX_FRAME)-1:0]        i_raw_count,
    input  logic [afp_pkg::afp_cnt_w(MAX_FRAME)-1:0]        i_logical_count,
    input  logic [afp_pkg::ExpW-1:0]                        i_expected_length,
    input  logic [7:0]                                      i_running_checksum,
    input  logic                                            i_escape_pending,
    output logic [afp_pkg::afp_cnt_w(MAX_FRAME)-1:0]        o_raw_count,
    output logic [afp_pkg::afp_cnt_w(MAX_FRAME)-1:0]        o_logical_count,
    output logic [afp_pkg::ExpW-1:0]                        o_expected_length,
    output logic [7:0]                                      o_running_checksum,
    output logic                                            o_escape_pending,
    output afp_pkg::t_result                                o_res
);
    import afp_pkg::*;

    localparam int unsigned CntW = afp_cnt_w(MAX_FRAME);

    logic [BoundW-1:0] limit;
    logic [CntW-1:0]   raw_nx;
    logic [CntW-1:0]   log_nx;
    logic [ExpW-1:0]   exp_nx;
    logic [7:0]        csum_nx;
    logic [7:0]        bx;
    logic              esc_skip;
    logic [BoundW-1:0] bound;
    logic              fault;
    logic              done;

    assign limit = ({{(BoundW-LenW){1'b0}}, i_cfg.max_frame_bytes} < BoundW'(MAX_FRAME))
                 ? {{(BoundW-LenW){1'b0}}, i_cfg.max_frame_bytes} : BoundW'(MAX_FRAME);
    assign raw_nx = i_raw_count + CntW'(1);
    assign log_nx = i_logical_count + CntW'(1);

    always_comb begin
        o_raw_count        = i_raw_count;
        o_logical_count    = i_logical_count;
        o_expected_length  = i_expected_length;
        o_running_checksum = i_running_checksum;
        o_escape_pending   = i_escape_pending;
        o_res              = '0;
        bx                 = i_byte;
        esc_skip           = 1'b0;
        exp_nx             = i_expected_length;
        csum_nx            = i_running_checksum;
        bound              = '0;
        fault              = 1'b0;
        done               = 1'b0;

        if (i_raw_count == '0) begin
            // hunt for the delimiter
            if (i_byte == i_cfg.frame_delimiter) begin
                o_raw_count        = CntW'(1);
                o_logical_count    = CntW'(1);
                o_expected_length  = '0;
                o_running_checksum = i_cfg.checksum_seed;
                o_escape_pending   = 1'b0;
                o_res.out_byte     = i_byte;
                o_res.byte_valid   = 1'b1;
            end
        end else begin
            o_raw_count = raw_nx;
            if (i_cfg.escaped_mode) begin
                if (i_escape_pending) begin
                    bx               = i_byte ^ i_cfg.escape_xor;
                    o_escape_pending = 1'b0;
                end else if (i_byte == i_cfg.escape_marker) begin
                    o_escape_pending = 1'b1;
                    esc_skip         = 1'b1;
                end
            end else begin
                o_escape_pending = 1'b0;
            end

            if (esc_skip) begin
                // drop the marker, but it still counts against the limit
                fault = BoundW'(raw_nx) > limit;
            end else begin
                if (log_nx == CntW'(2)) begin
                    exp_nx = {{(ExpW-8){1'b0}}, bx};
                end else if (log_nx == CntW'(3)) begin
                    exp_nx = {1'b0, i_expected_length[7:0], bx} + ExpW'(4);
                end else if (ExpW'(log_nx) != i_expected_length) begin
                    csum_nx = i_running_checksum - bx;
                end

                bound = (log_nx >= CntW'(3))
                      ? BoundW'(exp_nx) + BoundW'(raw_nx - log_nx)
                      : BoundW'(raw_nx);

                if (bound > limit) begin
                    fault = 1'b1;
                end else if (log_nx >= CntW'(4) && ExpW'(log_nx) == exp_nx) begin
                    if (bx == i_running_checksum) begin
                        done = 1'b1;
                    end else begin
                        fault = 1'b1;
                    end
                end

                if (!fault) begin
                    o_logical_count    = log_nx;
                    o_expected_length  = exp_nx;
                    o_running_checksum = csum_nx;
                    o_res.out_byte     = bx;
                    o_res.byte_valid   = 1'b1;
                    if (done) begin
                        o_res.frame_done        = 1'b1;
                        o_res.frame_raw_length  = LenW'(raw_nx);
                        o_res.frame_data_length = LenW'(log_nx);
                    end
                end
            end

            // drop back to hunting
            if (fault || done) begin
                o_raw_count        = '0;
                o_logical_count    = '0;
                o_expected_length  = '0;
                o_running_checksum = i_cfg.checksum_seed;
                o_escape_pending   = 1'b0;
                o_res.sync_lost    = fault;
            end
        end
    end

endmodule

// ----- rtl/api_frame_parser.sv -----
// Frame parser for a byte-wide radio-link receive stream.
// Input channel: one received byte per word on i_rx_byte (i_in_valid/o_in_ready).
// Output channel: exactly one result word per input byte (o_out_valid/i_out_ready):
// the unescaped frame byte with o_byte_valid, o_frame_done with the raw and
// unescaped frame lengths on a good checksum, and o_sync_lost when a frame is
// abandoned on a length or checksum fault. Idle bytes and escape markers give a
// result with all fields zero, except that a marker past the length limit sets
// o_sync_lost.
// Config channel: i_cfg_index selects escaped_mode, frame_delimiter,
// escape_marker, escape_xor, checksum_seed or max_frame_bytes; always ready,
// effective from the next byte. Indexes past the list are ignored.
// The result is registered and appears in the cycle after its byte is accepted.
// Throughput: one byte per cycle; the single output register is refilled in
// the same cycle it is drained, so o_in_ready drops only while a result is
// held and i_out_ready is low.
// Reset (synchronous, active low) returns the registers to their defaults,
// empties the output register and starts hunting for the delimiter.
module api_frame_parser #(
    parameter int unsigned MAX_FRAME = afp_pkg::MaxFrameDefault
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [7:0]                    i_rx_byte,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [7:0]                    o_out_byte,
    output logic                          o_byte_valid,
    output logic                          o_frame_done,
    output logic [afp_pkg::LenW-1:0]      o_frame_raw_length,
    output logic [afp_pkg::LenW-1:0]      o_frame_data_length,
    output logic                          o_sync_lost,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [afp_pkg::CfgIdxW-1:0]   i_cfg_index,
    input  logic [afp_pkg::CfgDataW-1:0]  i_cfg_data
);
    import afp_pkg::*;

    localparam int unsigned CntW = afp_cnt_w(MAX_FRAME);

    t_cfg            r_cfg;
    logic [CntW-1:0] r_raw_count;
    logic [CntW-1:0] r_logical_count;
    logic [ExpW-1:0] r_expected_length;
    logic [7:0]      r_running_checksum;
    logic            r_escape_pending;
    logic [CntW-1:0] n_raw_count;
    logic [CntW-1:0] n_logical_count;
    logic [ExpW-1:0] n_expected_length;
    logic [7:0]      n_running_checksum;
    logic            n_escape_pending;
    t_result         n_res;
    t_result         r_res;
    logic            r_out_valid;
    logic            in_acc;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_acc      = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.escaped_mode    <= 1'b0;
            r_cfg.frame_delimiter <= RstFrameDelimiter;
            r_cfg.escape_marker   <= RstEscapeMarker;
            r_cfg.escape_xor      <= RstEscapeXor;
            r_cfg.checksum_seed   <= RstChecksumSeed;
            r_cfg.max_frame_bytes <= RstMaxFrameBytes;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_ESCAPED_MODE:    r_cfg.escaped_mode    <= i_cfg_data[0];
                CFG_FRAME_DELIMITER: r_cfg.frame_delimiter <= i_cfg_data[7:0];
                CFG_ESCAPE_MARKER:   r_cfg.escape_marker   <= i_cfg_data[7:0];
                CFG_ESCAPE_XOR:      r_cfg.escape_xor      <= i_cfg_data[7:0];
                CFG_CHECKSUM_SEED:   r_cfg.checksum_seed   <= i_cfg_data[7:0];
                CFG_MAX_FRAME_BYTES: r_cfg.max_frame_bytes <= i_cfg_data;
                default: ;
            endcase
        end
    end

    afp_step #(
        .MAX_FRAME (MAX_FRAME)
    ) u_step (
        .i_cfg              (r_cfg),
        .i_byte             (i_rx_byte),
        .i_raw_count        (r_raw_count),
        .i_logical_count    (r_logical_count),
        .i_expected_length  (r_expected_length),
        .i_running_checksum (r_running_checksum),
        .i_escape_pending   (r_escape_pending),
        .o_raw_count        (n_raw_count),
        .o_logical_count    (n_logical_count),
        .o_expected_length  (n_expected_length),
        .o_running_checksum (n_running_checksum),
        .o_escape_pending   (n_escape_pending),
        .o_res              (n_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_raw_count        <= '0;
            r_logical_count    <= '0;
            r_expected_length  <= '0;
            r_running_checksum <= RstChecksumSeed;
            r_escape_pending   <= 1'b0;
            r_out_valid        <= 1'b0;
        end else begin
            if (in_acc) begin
                r_raw_count        <= n_raw_count;
                r_logical_count    <= n_logical_count;
                r_expected_length  <= n_expected_length;
                r_running_checksum <= n_running_checksum;
                r_escape_pending   <= n_escape_pending;
                r_out_valid        <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result register: load on accept, hold while stalled
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_res <= n_res;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_out_byte          = r_res.out_byte;
    assign o_byte_valid        = r_res.byte_valid;
    assign o_frame_done        = r_res.frame_done;
    assign o_frame_raw_length  = r_res.frame_raw_length;
    assign o_frame_data_length = r_res.frame_data_length;
    assign o_sync_lost         = r_res.sync_lost;

    a_done_has_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_frame_done) |-> (o_byte_valid && !o_sync_lost))
        else $error("frame_done without a valid byte");

    a_lost_no_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_sync_lost) |-> (!o_byte_valid && o_out_byte == 8'd0))
        else $error("sync_lost with a frame byte");

    a_log_le_raw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_logical_count <= r_raw_count)
        else $error("logical count exceeds raw count");

    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && r_raw_count == '0 && i_rx_byte == r_cfg.frame_delimiter)
        |=> (r_raw_count == CntW'(1) && r_logical_count == CntW'(1)))
        else $error("delimiter did not start a frame");

    a_done_hunts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (n_res.frame_done || n_res.sync_lost)) |=> (r_raw_count == '0))
        else $error("parser did not return to hunting");

endmodule

// ----- tb/tb_api_frame_parser.sv -----
`timescale 1ns / 1ps

module tb_api_frame_parser;
    import afp_pkg::*;

    localparam int unsigned MaxFrame    = MaxFrameDefault;
    localparam int unsigned PhaseBytes  = 170;
    localparam int unsigned NumPhases   = 11;
    localparam int unsigned QuietLimit  = 2000;
    localparam int unsigned HoldCycles  = 120;
    localparam int unsigned HoldAfter   = 600;

    // indexes past the register list; the block must ignore them
    localparam logic [CfgIdxW-1:0] CFG_SPARE_A = 3'd6;
    localparam logic [CfgIdxW-1:0] CFG_SPARE_B = 3'd7;

    typedef enum {
        FLAW_NONE,
        FLAW_CHECKSUM,
        FLAW_OVERSIZE,
        FLAW_TRUNCATE,
        FLAW_CORRUPT
    } t_frame_flaw;

    class t_result_board;
        t_cfg        cfg;
        t_result     awaited_results[$];
        int          fail_count;
        int unsigned frame_raw;
        int unsigned frame_data;
        int unsigned frame_len;
        int unsigned chk_acc;
        bit          esc_open;

        function new();
            cfg.escaped_mode    = 1'b0;
            cfg.frame_delimiter = RstFrameDelimiter;
            cfg.escape_marker   = RstEscapeMarker;
            cfg.escape_xor      = RstEscapeXor;
            cfg.checksum_seed   = RstChecksumSeed;
            cfg.max_frame_bytes = RstMaxFrameBytes;
            fail_count = 0;
            restart();
        endfunction

        function void restart();
            frame_raw  = 0;
            frame_data = 0;
            frame_len  = 0;
            chk_acc    = 32'(cfg.checksum_seed);
            esc_open   = 1'b0;
        endfunction

        function void apply_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
            case (idx)
                CFG_ESCAPED_MODE:    cfg.escaped_mode    = data[0];
                CFG_FRAME_DELIMITER: cfg.frame_delimiter = data[7:0];
                CFG_ESCAPE_MARKER:   cfg.escape_marker   = data[7:0];
                CFG_ESCAPE_XOR:      cfg.escape_xor      = data[7:0];
                CFG_CHECKSUM_SEED:   cfg.checksum_seed   = data[7:0];
                CFG_MAX_FRAME_BYTES: cfg.max_frame_bytes = data;
                default: ;
            endcase
        endfunction

        // work out the result word that one accepted byte causes
        function void note_rx_byte(logic [7:0] rx);
            t_result     r;
            int unsigned b;
            int unsigned lim;
            int unsigned bound;
            bit          fault;
            bit          done;
            r     = '0;
            fault = 1'b0;
            done  = 1'b0;
            b     = 32'(rx);
            lim   = (cfg.max_frame_bytes > MaxFrame) ? MaxFrame : cfg.max_frame_bytes;
            if (frame_raw == 0) begin
                if (b == cfg.frame_delimiter) begin
                    restart();
                    frame_raw    = 1;
                    frame_data   = 1;
                    r.out_byte   = b[7:0];
                    r.byte_valid = 1'b1;
                end
                awaited_results.push_back(r);
                return;
            end
            frame_raw++;
            if (cfg.escaped_mode) begin
                if (esc_open) begin
                    b = (b ^ cfg.escape_xor) & 32'hFF;
                    esc_open = 1'b0;
                end else if (b == cfg.escape_marker) begin
                    // drop the marker, but it still counts against the bound
                    esc_open = 1'b1;
                    if (frame_raw > lim) begin
                        r.sync_lost = 1'b1;
                        restart();
                    end
                    awaited_results.push_back(r);
                    return;
                end
            end else begin
                esc_open = 1'b0;
            end
            frame_data++;
            if (frame_data == 2)
                frame_len = b;
            else if (frame_data == 3)
                frame_len = (((frame_len & 32'hFF) << 8) | b) + 32'd4;
            else if (frame_data != frame_len)
                chk_acc = (chk_acc - b) & 32'hFF;
            bound = (frame_data >= 3) ? frame_len + (frame_raw - frame_data) : frame_raw;
            if (bound > lim)
                fault = 1'b1;
            else if (frame_data >= 4 && frame_data == frame_len) begin
                if (b == chk_acc)
                    done = 1'b1;
                else
                    fault = 1'b1;
            end
            if (fault) begin
                r.sync_lost = 1'b1;
                restart();
            end else begin
                r.out_byte   = b[7:0];
                r.byte_valid = 1'b1;
                if (done) begin
                    r.frame_done        = 1'b1;
                    r.frame_raw_length  = frame_raw[LenW-1:0];
                    r.frame_data_length = frame_data[LenW-1:0];
                    restart();
                end
            end
            awaited_results.push_back(r);
        endfunction

        function void cmp_field(string name, logic [LenW-1:0] want, logic [LenW-1:0] got);
            if (want !== got) begin
                fail_count++;
                $display("%0t: %s mismatch: expected %0d, actual %0d",
                         $time, name, want, got);
            end
        endfunction

        function void check_result(logic [7:0] out_byte, logic byte_valid, logic frame_done,
                                   logic [LenW-1:0] raw_len, logic [LenW-1:0] data_len,
                                   logic sync_lost);
            t_result want;
            if (awaited_results.size() == 0) begin
                fail_count++;
                $display("%0t: result word with nothing awaited: expected none, actual byte %0d",
                         $time, out_byte);
            end else begin
                want = awaited_results.pop_front();
                cmp_field("out_byte", LenW'(want.out_byte), LenW'(out_byte));
                cmp_field("byte_valid", LenW'(want.byte_valid), LenW'(byte_valid));
                cmp_field("frame_done", LenW'(want.frame_done), LenW'(frame_done));
                cmp_field("frame_raw_length", want.frame_raw_length, raw_len);
                cmp_field("frame_data_length", want.frame_data_length, data_len);
                cmp_field("sync_lost", LenW'(want.sync_lost), LenW'(sync_lost));
            end
        endfunction
    endclass

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    logic [7:0]          i_rx_byte   = 8'd0;
    logic                i_out_ready = 1'b0;
    logic                i_cfg_valid = 1'b0;
    logic [CfgIdxW-1:0]  i_cfg_index = '0;
    logic [CfgDataW-1:0] i_cfg_data  = '0;
    logic                o_in_ready;
    logic                o_out_valid;
    logic [7:0]          o_out_byte;
    logic                o_byte_valid;
    logic                o_frame_done;
    logic [LenW-1:0]     o_frame_raw_length;
    logic [LenW-1:0]     o_frame_data_length;
    logic                o_sync_lost;
    logic                o_cfg_ready;

    t_result_board     board = new();
    logic [7:0]        tx_bytes[$];
    logic [7:0]        frame_bytes[$];
    bit                tx_calm = 1'b0;
    int unsigned       results_seen = 0;
    int unsigned       quiet_cycles = 0;

    api_frame_parser #(.MAX_FRAME(MaxFrame)) uut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_rx_byte           (i_rx_byte),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_out_byte          (o_out_byte),
        .o_byte_valid        (o_byte_valid),
        .o_frame_done        (o_frame_done),
        .o_frame_raw_length  (o_frame_raw_length),
        .o_frame_data_length (o_frame_data_length),
        .o_sync_lost         (o_sync_lost),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && i_cfg_valid && o_cfg_ready)
            board.apply_reg(i_cfg_index, i_cfg_data);
        if (i_rst_n && i_in_valid && o_in_ready)
            board.note_rx_byte(i_rx_byte);
        if (i_rst_n && o_out_valid && i_out_ready) begin
            board.check_result(o_out_byte, o_byte_valid, o_frame_done,
                               o_frame_raw_length, o_frame_data_length, o_sync_lost);
            results_seen <= results_seen + 1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        while (quiet_cycles < QuietLimit)
            @(posedge i_clk);
        $display("CHECK FAILED");
        $finish;
    end

    // mostly short gaps, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(25, 60);
    endfunction

    initial begin
        int unsigned run_len;
        int unsigned stall_len;
        bit          held_off;
        held_off = 1'b0;
        while (!i_rst_n)
            @(posedge i_clk);
        forever begin
            // hold off once for a long stretch so the input side backs up
            if (!held_off && results_seen >= HoldAfter) begin
                held_off = 1'b1;
                i_out_ready <= 1'b0;
                repeat (HoldCycles) @(posedge i_clk);
            end
            run_len = ($urandom_range(0, 99) < 15) ? $urandom_range(50, 200)
                                                    : $urandom_range(1, 8);
            i_out_ready <= 1'b1;
            repeat (run_len) @(posedge i_clk);
            stall_len = pick_gap();
            if (stall_len > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall_len) @(posedge i_clk);
            end
        end
    end

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic apply_settings(input logic mode, input logic [7:0] delim,
                                  input logic [7:0] marker, input logic [7:0] mask,
                                  input logic [7:0] seed, input logic [LenW-1:0] maxb);
        logic [CfgDataW-1:0] noise;
        noise = CfgDataW'($urandom);
        // upper data bits are don't-care for the narrow registers
        write_reg(CFG_ESCAPED_MODE, {noise[10:1], mode});
        write_reg(CFG_FRAME_DELIMITER, {noise[10:8], delim});
        write_reg(CFG_ESCAPE_MARKER, {noise[2:0], marker});
        write_reg(CFG_ESCAPE_XOR, {noise[5:3], mask});
        write_reg(CFG_CHECKSUM_SEED, {noise[8:6], seed});
        write_reg(CFG_MAX_FRAME_BYTES, maxb);
    endtask

    task automatic wait_idle();
        while (board.awaited_results.size() != 0)
            @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    // send every queued byte; at pause_at, hold until all results are back
    task automatic send_stream(input int pause_at);
        int unsigned gap;
        for (int i = 0; i < tx_bytes.size(); i++) begin
            gap = tx_calm ? 0 : pick_gap();
            if (i == pause_at || gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
                if (i == pause_at) begin
                    @(posedge i_clk);
                    while (board.awaited_results.size() != 0)
                        @(posedge i_clk);
                end
            end
            i_in_valid <= 1'b1;
            i_rx_byte  <= tx_bytes[i];
            do @(posedge i_clk); while (!o_in_ready);
        end
        i_in_valid <= 1'b0;
        tx_bytes.delete();
    endtask

    // in escaped mode: escape markers always, other bytes now and then
    function automatic void push_coded(input logic [7:0] b);
        if (board.cfg.escaped_mode
                && (b == board.cfg.escape_marker || $urandom_range(0, 7) == 0)) begin
            frame_bytes.push_back(board.cfg.escape_marker);
            frame_bytes.push_back(b ^ board.cfg.escape_xor);
        end else begin
            frame_bytes.push_back(b);
        end
    endfunction

    function automatic void add_frame(input int unsigned len, input t_frame_flaw flaw);
        logic [7:0]  sum;
        logic [7:0]  pick;
        int unsigned cut;
        int unsigned at;
        int unsigned k;
        frame_bytes.delete();
        frame_bytes.push_back(board.cfg.frame_delimiter);
        push_coded(len[15:8]);
        push_coded(len[7:0]);
        // an oversized length faults at once; skip the body
        if (flaw != FLAW_OVERSIZE) begin
            sum = board.cfg.checksum_seed;
            for (k = 0; k < len; k++) begin
                pick = 8'($urandom);
                sum  = sum - pick;
                push_coded(pick);
            end
            if (flaw == FLAW_CHECKSUM) begin
                pick = 8'($urandom_range(1, 255));
                sum  = sum ^ pick;
            end
            push_coded(sum);
            if (flaw == FLAW_TRUNCATE) begin
                cut = $urandom_range(1, 3);
                repeat (cut) void'(frame_bytes.pop_back());
            end else if (flaw == FLAW_CORRUPT) begin
                at   = $urandom_range(1, frame_bytes.size() - 1);
                pick = 8'($urandom_range(1, 255));
                frame_bytes[at] = frame_bytes[at] ^ pick;
            end
        end
        foreach (frame_bytes[j])
            tx_bytes.push_back(frame_bytes[j]);
    endfunction

    function automatic void build_phase(input int unsigned target);
        int unsigned lim;
        int unsigned len;
        int unsigned r;
        int unsigned n;
        lim = (board.cfg.max_frame_bytes > MaxFrame) ? MaxFrame : board.cfg.max_frame_bytes;
        while (tx_bytes.size() < target) begin
            len = $urandom_range(0, 16);
            r   = $urandom_range(0, 99);
            if (r < 3)
                len = $urandom_range(100, 400);
            else if (r < 15 && lim >= 4 && lim <= 64)
                len = $urandom_range((lim > 6) ? lim - 6 : 0, lim - 4);
            r = $urandom_range(0, 99);
            if (r < 72)
                add_frame(len, FLAW_NONE);
            else if (r < 80)
                add_frame(len, FLAW_CHECKSUM);
            else if (r < 86)
                add_frame($urandom_range((lim > 3) ? lim - 3 : 0, 65535), FLAW_OVERSIZE);
            else if (r < 91)
                add_frame(len, FLAW_TRUNCATE);
            else if (r < 96)
                add_frame(len, FLAW_CORRUPT);
            else begin
                n = $urandom_range(1, 5);
                repeat (n) tx_bytes.push_back(8'($urandom));
            end
        end
    endfunction

    initial begin
        logic            mode;
        logic [7:0]      delim;
        logic [7:0]      marker;
        logic [7:0]      mask;
        logic [7:0]      seed;
        logic [LenW-1:0] maxb;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // plain frames at reset values: delimiter as payload, bad checksum on a
        // delimiter-valued byte followed by a non-delimiter, oversized length
        tx_bytes = '{8'h7E, 8'h00, 8'h01, 8'h7E, 8'h81,
                     8'h7E, 8'h00, 8'h00, 8'h7E, 8'h01,
                     8'h7E, 8'hFF, 8'hFF};
        send_stream(-1);
        wait_idle();

        // escaped frame with marker after marker, then a frame left with an open escape
        write_reg(CFG_ESCAPED_MODE, 11'd1);
        tx_bytes = '{8'h7E, 8'h00, 8'h02, 8'h7D, 8'h5D, 8'h7D, 8'h7D, 8'h25,
                     8'h7E, 8'h00, 8'h01, 8'h7D};
        send_stream(-1);
        wait_idle();

        // leave escaped mode mid-frame: drop the open escape
        write_reg(CFG_ESCAPED_MODE, 11'd0);
        tx_bytes = '{8'h41, 8'hBE};
        send_stream(-1);
        wait_idle();

        for (int p = 0; p < NumPhases; p++) begin
            mode   = 1'($urandom_range(0, 1));
            delim  = 8'($urandom);
            marker = 8'($urandom);
            mask   = 8'($urandom);
            seed   = 8'($urandom);
            maxb   = LenW'($urandom_range(5, 1024));
            case (p)
                0: begin
                    mode   = 1'b0;
                    delim  = RstFrameDelimiter;
                    marker = RstEscapeMarker;
                    mask   = RstEscapeXor;
                    seed   = RstChecksumSeed;
                    maxb   = RstMaxFrameBytes;
                end
                1: begin
                    mode   = 1'b1;
                    delim  = RstFrameDelimiter;
                    marker = RstEscapeMarker;
                    mask   = RstEscapeXor;
                    seed   = RstChecksumSeed;
                    maxb   = RstMaxFrameBytes;
                end
                2: begin
                    mode   = 1'b1;
                    delim  = 8'h00;
                    marker = 8'hFF;
                    mask   = 8'hFF;
                    seed   = 8'h00;
                    maxb   = 11'd2047;
                end
                3: begin
                    mode   = 1'b0;
                    delim  = 8'hFF;
                    marker = 8'h00;
                    mask   = 8'h00;
                    seed   = 8'hFF;
                    maxb   = 11'd40;
                end
                4: begin
                    mode = 1'b1;
                    maxb = 11'd5;
                end
                5: begin
                    mode = 1'b1;
                    mask = 8'h00;
                    maxb = 11'd3;
                end
                6: begin
                    mode = 1'b0;
                    maxb = 11'd0;
                end
                7: begin
                    mode = 1'b1;
                    maxb = 11'd300;
                end
                9: begin
                    mode = 1'b0;
                    maxb = 11'd16;
                end
                10: begin
                    mode = 1'b1;
                    maxb = 11'd1024;
                end
                default: ;
            endcase
            apply_settings(mode, delim, marker, mask, seed, maxb);
            if (p == 2) begin
                write_reg(CFG_SPARE_A, CfgDataW'($urandom));
                write_reg(CFG_SPARE_B, CfgDataW'($urandom));
            end
            tx_calm = (p == 10);
            build_phase(PhaseBytes);
            send_stream((p == 1) ? tx_bytes.size() / 2 : -1);
            wait_idle();
        end

        repeat (4) @(posedge i_clk);
        if (board.awaited_results.size() != 0) begin
            board.fail_count++;
            $display("%0t: missing result words: expected %0d more, actual 0",
                     $time, board.awaited_results.size());
        end
        if (board.fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ----- api_frame_parser.f -----
rtl/afp_pkg.sv
rtl/afp_step.sv
rtl/api_frame_parser.sv
tb/tb_api_frame_parser.sv
